@@ rtl/b64e_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// b64e_pkg
// Shared types, constants and the alphabet lookup for the base64 encoder.
// ----------------------------------------------------------------------------
package b64e_pkg;

    localparam logic [6:0] PAD_CHAR = 7'h3D;  // '='

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } t_in_item;

    typedef struct packed {
        logic [6:0] code_char;
        logic       end_of_output;
    } t_out_item;

    // One group handed from the front to the back.
    typedef struct packed {
        logic [23:0] word;    // first byte in the top eight bits
        logic [1:0]  nbytes;  // 1 to 3 real bytes in the word
        logic        last;    // group closes the message
    } t_group;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // Standard alphabet: A-Z, a-z, 0-9, '+', '/'.
    function automatic logic [6:0] b64_char(input logic [5:0] v);
        logic [6:0] c;
        if (v < 6'd26) begin
            c = 7'h41 + {1'b0, v};
        end else if (v < 6'd52) begin
            c = 7'h61 + {1'b0, v} - 7'd26;
        end else if (v < 6'd62) begin
            c = 7'h30 + {1'b0, v} - 7'd52;
        end else if (v == 6'd62) begin
            c = 7'h2B;
        end else begin
            c = 7'h2F;
        end
        return c;
    endfunction

endpackage
`default_nettype wire

@@ rtl/base64_stream_encoder.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// base64_stream_encoder
// Streaming base64 encoder, standard alphabet with '=' padding.
// ----------------------------------------------------------------------------
//   channel | direction | handshake          | payload
//   input   | in        | i_valid / o_stall  | i_item  (data_byte, final_byte)
//   output  | out       | o_valid / i_stall  | o_item  (code_char, end_of_output)
//
// One byte is taken per cycle while the group queue has room; one character
// leaves per cycle from the output register while the output is not stalled.
// A byte that closes a group is pushed into the queue, taken into the back's
// group register, and its first character is then registered for output.
// Reset is synchronous and clears the group count, queue pointers and valids.
// A stall on the output holds the character register; the queue soaks up
// groups so the input keeps flowing until it fills.
// ----------------------------------------------------------------------------
module base64_stream_encoder #(
    parameter int Q_DEPTH = 2
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_stall,
    input  b64e_pkg::t_in_item   i_item,
    output logic                 o_valid,
    input  wire                  i_stall,
    output b64e_pkg::t_out_item  o_item
);
    import b64e_pkg::*;

    t_group    w_push_group;
    t_group    w_head_group;
    t_q_status w_q_status;
    logic      w_push;
    logic      w_pop;

    // Front: gather bytes, close groups on the third or final byte.
    b64e_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_item     (i_item),
        .i_q_status (w_q_status),
        .o_push     (w_push),
        .o_group    (w_push_group)
    );

    // Queue: decouple byte intake from character output.
    b64e_queue #(
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_group  (w_push_group),
        .i_pop    (w_pop),
        .o_group  (w_head_group),
        .o_status (w_q_status)
    );

    // Back: emit four characters per group, padding short final groups.
    b64e_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_group    (w_head_group),
        .i_q_status (w_q_status),
        .o_pop      (w_pop),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_item     (o_item)
    );

endmodule
`default_nettype wire

@@ rtl/b64e_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// b64e_front
// Gathers input bytes into groups of three and pushes each closed group.
// ----------------------------------------------------------------------------
module b64e_front (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_stall,
    input  b64e_pkg::t_in_item   i_item,
    input  b64e_pkg::t_q_status  i_q_status,
    output logic                 o_push,
    output b64e_pkg::t_group     o_group
);
    import b64e_pkg::*;

    logic [1:0]  r_count;
    logic [1:0]  n_count;
    logic [15:0] r_bytes;
    logic [15:0] n_bytes;
    logic        w_accept;

    assign o_stall  = i_q_status.full;
    assign w_accept = i_valid && !o_stall;
    // Close the group on its third byte or on the final byte.
    assign o_push   = w_accept && (i_item.final_byte || r_count == 2'd2);

    always_comb begin
        o_group.nbytes = r_count + 2'd1;
        o_group.last   = i_item.final_byte;
        unique case (r_count)
            2'd0:    o_group.word = {i_item.data_byte, 16'h0000};
            2'd1:    o_group.word = {r_bytes[7:0], i_item.data_byte, 8'h00};
            default: o_group.word = {r_bytes, i_item.data_byte};
        endcase
    end

    always_comb begin
        n_count = r_count;
        n_bytes = r_bytes;
        if (o_push) begin
            n_count = 2'd0;
            n_bytes = 16'h0000;
        end else if (w_accept) begin
            n_count = r_count + 2'd1;
            n_bytes = {r_bytes[7:0], i_item.data_byte};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
            r_bytes <= 16'h0000;
        end else begin
            r_count <= n_count;
            r_bytes <= n_bytes;
        end
    end

endmodule
`default_nettype wire

@@ rtl/b64e_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// b64e_queue
// Short first-in first-out queue of groups between front and back.
// ----------------------------------------------------------------------------
module b64e_queue #(
    parameter int DEPTH = 2
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push,
    input  b64e_pkg::t_group     i_group,
    input  wire                  i_pop,
    output b64e_pkg::t_group     o_group,
    output b64e_pkg::t_q_status  o_status
);
    import b64e_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_group        r_slot [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic [PW-1:0] n_wr;
    logic [PW-1:0] n_rd;
    logic [CW-1:0] n_cnt;

    assign o_status.full  = (r_cnt == CW'(DEPTH));
    assign o_status.empty = (r_cnt == '0);
    assign o_group        = r_slot[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_group;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && !i_pop |-> !o_status.full)
        else $error("group pushed into a full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_status.empty)
        else $error("group popped from an empty queue");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH))
        else $error("queue count beyond depth");
`endif

endmodule
`default_nettype wire

@@ rtl/b64e_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// b64e_back
// Expands each group into four characters, one per cycle while the output is
// not stalled, into the output register.
// ----------------------------------------------------------------------------
module b64e_back (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  b64e_pkg::t_group     i_group,
    input  b64e_pkg::t_q_status  i_q_status,
    output logic                 o_pop,
    output logic                 o_valid,
    input  wire                  i_stall,
    output b64e_pkg::t_out_item  o_item
);
    import b64e_pkg::*;

    t_group    r_grp;
    logic      r_busy;
    logic      n_busy;
    logic [1:0] r_idx;
    logic [1:0] n_idx;
    logic      r_out_valid;
    logic      n_out_valid;
    t_out_item r_out;
    t_out_item w_char;
    logic [5:0] w_sextet;
    logic      w_out_free;
    logic      w_load;

    assign w_out_free = !r_out_valid || !i_stall;
    assign w_load     = r_busy && w_out_free;
    // Take the next group when idle or while its predecessor sends its last char.
    assign o_pop      = !i_q_status.empty && (!r_busy || (w_load && r_idx == 2'd3));

    always_comb begin
        unique case (r_idx)
            2'd0:    w_sextet = r_grp.word[23:18];
            2'd1:    w_sextet = r_grp.word[17:12];
            2'd2:    w_sextet = r_grp.word[11:6];
            default: w_sextet = r_grp.word[5:0];
        endcase
        w_char.code_char     = b64_char(w_sextet);
        w_char.end_of_output = (r_idx == 2'd3) && r_grp.last;
        if ((r_idx == 2'd3 && r_grp.nbytes < 2'd3) ||
            (r_idx == 2'd2 && r_grp.nbytes < 2'd2)) begin
            w_char.code_char = PAD_CHAR;
        end
    end

    always_comb begin
        n_busy      = r_busy;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && i_stall;
        if (w_load) begin
            n_out_valid = 1'b1;
            n_idx       = r_idx + 2'd1;
            if (r_idx == 2'd3) begin
                n_busy = 1'b0;
            end
        end
        if (o_pop) begin
            n_busy = 1'b1;
            n_idx  = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_grp <= i_group;
        end
        if (w_load) begin
            r_out <= w_char;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

`ifndef SYNTHESIS
    a_idle_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> r_idx == 2'd0)
        else $error("character index moved while idle");
    a_group_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load && r_idx == 2'd3 |=> r_idx == 2'd0)
        else $error("character index did not wrap after fourth char");
    a_pop_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && r_busy |-> w_load && r_idx == 2'd3)
        else $error("group taken while previous group still unfinished");
`endif

endmodule
`default_nettype wire
